// ===== rtl/arle_pkg.sv =====
// ----------------------------------------------------------------------------
// arle_pkg: shared types for the ARGB plane RLE encoder
// Command and status bundles between controller, datapath and byte packer.
// ----------------------------------------------------------------------------
package arle_pkg;

  localparam logic [7:0] REP_HDR_BASE = 8'h80;
  localparam logic [7:0] REP_MIN_LEN  = 8'd3;

  typedef enum logic [2:0] {
    DEC_NONE,
    DEC_REP_START,
    DEC_REP_INC,
    DEC_LIT_STORE,
    DEC_TRIPLE
  } dec_op_e;

  typedef enum logic [1:0] {
    SRC_LIT_HDR,
    SRC_LIT_BYTE,
    SRC_REP_HDR,
    SRC_REP_VAL
  } byte_src_e;

  typedef struct packed {
    logic      load;
    dec_op_e   dec_op;
    logic [1:0] di;
    logic      ptr_clr;
    logic      ptr_inc;
    logic      ram_re;
    byte_src_e src;
    logic      lit_clr;
    logic      rep_end;
    logic      shift;
    logic      clear_all;
  } dp_cmd_t;

  typedef struct packed {
    logic       mode;
    logic       rlen_zero;
    logic       b_eq_rv;
    logic       rep_full;
    logic       triple;
    logic       lit_full;
    logic       llen_zero;
    logic       lit_ptr_last;
    logic       rlen_ge3;
    logic       rep_ptr_last;
    logic       last;
    logic [1:0] fill;
  } dp_stat_t;

  typedef struct packed {
    logic push;
    logic flush;
    logic done;
  } pk_cmd_t;

  typedef struct packed {
    logic can_push;
    logic empty;
  } pk_stat_t;

endpackage

// ===== rtl/arle_if.sv =====
// ----------------------------------------------------------------------------
// arle_if: stream interfaces of the ARGB plane RLE encoder
// Input byte beats and packed output word beats, valid/ready handshake.
// ----------------------------------------------------------------------------
interface arle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plane_byte;
  logic       plane_last;

  modport source (output valid, output plane_byte, output plane_last, input ready);
  modport sink   (input valid, input plane_byte, input plane_last, output ready);
endinterface

interface arle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_bytes;
  logic [3:0]  byte_count;
  logic        plane_done;

  modport source (output valid, output packed_bytes, output byte_count, output plane_done,
                  input ready);
  modport sink   (input valid, input packed_bytes, input byte_count, input plane_done,
                  output ready);
endinterface

// ===== rtl/arle_ram.sv =====
// ----------------------------------------------------------------------------
// arle_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module arle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/arle_pack.sv =====
// ----------------------------------------------------------------------------
// arle_pack: byte packer and output register
// Collects encoded bytes eight to a word; a flush closes a partial word.
// ----------------------------------------------------------------------------
module arle_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arle_pkg::pk_cmd_t cmd_i,
  input  logic [7:0]        byte_i,
  output arle_pkg::pk_stat_t stat_o,
  arle_out_if.source        word_o
);
  import arle_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        valid_q;
  logic [63:0] word_q;
  logic [3:0]  wcnt_q;
  logic        done_q;
  logic        out_free;
  logic        move;

  assign out_free = !valid_q || word_o.ready;
  assign move     = out_free && ((cmd_i.push && cnt_q == 4'd8) ||
                                 (cmd_i.flush && cnt_q != 4'd0));

  assign stat_o.can_push = (cnt_q != 4'd8) || out_free;
  assign stat_o.empty    = (cnt_q == 4'd0);

  always_comb begin
    logic [3:0] base;
    base  = move ? 4'd0 : cnt_q;
    acc_d = move ? 64'd0 : acc_q;
    cnt_d = base;
    if (cmd_i.push) begin
      acc_d[{base[2:0], 3'b000} +: 8] = byte_i;
      cnt_d = base + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (move) begin
        valid_q <= 1'b1;
      end else if (word_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      word_q <= acc_q;
      wcnt_q <= cnt_q;
      done_q <= cmd_i.flush && cmd_i.done;
    end
  end

  assign word_o.valid        = valid_q;
  assign word_o.packed_bytes = word_q;
  assign word_o.byte_count   = wcnt_q;
  assign word_o.plane_done   = done_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd8)
    else $error("packer byte count out of range");
`endif

endmodule

// ===== rtl/arle_dp.sv =====
// ----------------------------------------------------------------------------
// arle_dp: encoder datapath
// Lookahead window, literal store, run counters and the emitted byte mux.
// ----------------------------------------------------------------------------
module arle_dp #(
  parameter int MAX_RUN = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arle_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]         plane_byte_i,
  input  logic               plane_last_i,
  output arle_pkg::dp_stat_t stat_o,
  output logic [7:0]         push_byte_o
);
  import arle_pkg::*;

  localparam int AW = $clog2(MAX_RUN);
  localparam int LW = $clog2(MAX_RUN + 1);

  logic [7:0]    la_q [3];
  logic [1:0]    fill_q;
  logic          last_q;
  logic [LW-1:0] llen_q;
  logic [7:0]    rv_q;
  logic [LW-1:0] rlen_q;
  logic          mode_q;
  logic [AW-1:0] ptr_q;
  logic [7:0]    cur_byte;
  logic [7:0]    ram_rdata;
  logic [LW-1:0] ptr_p1;

  assign cur_byte = la_q[cmd_i.di];
  assign ptr_p1   = LW'(ptr_q) + LW'(1);

  assign stat_o.mode         = mode_q;
  assign stat_o.rlen_zero    = (rlen_q == '0);
  assign stat_o.b_eq_rv      = (cur_byte == rv_q);
  assign stat_o.rep_full     = (rlen_q + LW'(1)) >= LW'(MAX_RUN);
  assign stat_o.triple       = (fill_q == 2'd3) && (cmd_i.di == 2'd0) &&
                               (la_q[0] == la_q[1]) && (la_q[0] == la_q[2]);
  assign stat_o.lit_full     = (llen_q + LW'(1)) >= LW'(MAX_RUN);
  assign stat_o.llen_zero    = (llen_q == '0);
  assign stat_o.lit_ptr_last = (ptr_p1 == llen_q);
  assign stat_o.rlen_ge3     = (rlen_q >= LW'(3));
  assign stat_o.rep_ptr_last = (ptr_p1 == rlen_q);
  assign stat_o.last         = last_q;
  assign stat_o.fill         = fill_q;

  always_comb begin
    unique case (cmd_i.src)
      SRC_LIT_HDR:  push_byte_o = 8'(llen_q - LW'(1));
      SRC_LIT_BYTE: push_byte_o = ram_rdata;
      SRC_REP_HDR:  push_byte_o = stat_o.rlen_ge3 ? (REP_HDR_BASE + 8'(rlen_q) - REP_MIN_LEN)
                                                  : 8'(rlen_q - LW'(1));
      SRC_REP_VAL:  push_byte_o = rv_q;
      default:      push_byte_o = rv_q;
    endcase
  end

  arle_ram #(
    .WIDTH (8),
    .DEPTH (MAX_RUN)
  ) u_lit_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.dec_op == DEC_LIT_STORE),
    .waddr_i (llen_q[AW-1:0]),
    .wdata_i (cur_byte),
    .re_i    (cmd_i.ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q[0] <= '0;
      la_q[1] <= '0;
      la_q[2] <= '0;
      fill_q  <= '0;
      last_q  <= 1'b0;
      llen_q  <= '0;
      rv_q    <= '0;
      rlen_q  <= '0;
      mode_q  <= 1'b0;
      ptr_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        la_q[fill_q] <= plane_byte_i;
        fill_q       <= fill_q + 2'd1;
        last_q       <= plane_last_i;
      end
      unique case (cmd_i.dec_op)
        DEC_NONE: ;
        DEC_REP_START: begin
          rv_q   <= cur_byte;
          rlen_q <= LW'(1);
        end
        DEC_REP_INC: rlen_q <= rlen_q + LW'(1);
        DEC_LIT_STORE: begin
          llen_q <= llen_q + LW'(1);
          if (stat_o.lit_full) begin
            mode_q <= 1'b1;
          end
        end
        DEC_TRIPLE: begin
          mode_q <= 1'b1;
          rv_q   <= cur_byte;
          rlen_q <= LW'(1);
        end
        default: ;
      endcase
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + AW'(1);
      end
      if (cmd_i.lit_clr) begin
        llen_q <= '0;
      end
      if (cmd_i.rep_end) begin
        rlen_q <= '0;
        mode_q <= 1'b0;
      end
      if (cmd_i.shift) begin
        la_q[0] <= la_q[1];
        la_q[1] <= la_q[2];
        fill_q  <= 2'd2;
      end
      if (cmd_i.clear_all) begin
        la_q[0] <= '0;
        la_q[1] <= '0;
        la_q[2] <= '0;
        fill_q  <= '0;
        last_q  <= 1'b0;
        llen_q  <= '0;
        rv_q    <= '0;
        rlen_q  <= '0;
        mode_q  <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/arle_ctrl.sv =====
// ----------------------------------------------------------------------------
// arle_ctrl: encoder controller
// Sequences byte decisions, run emission and the end-of-burst flush.
// ----------------------------------------------------------------------------
module arle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  arle_pkg::dp_stat_t  dp_stat_i,
  input  arle_pkg::pk_stat_t  pk_stat_i,
  output arle_pkg::dp_cmd_t   dp_cmd_o,
  output arle_pkg::pk_cmd_t   pk_cmd_o
);
  import arle_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECIDE  = 4'd1;
  localparam logic [3:0] ST_LIT_HDR = 4'd2;
  localparam logic [3:0] ST_LIT_RD  = 4'd3;
  localparam logic [3:0] ST_LIT_WR  = 4'd4;
  localparam logic [3:0] ST_REP_HDR = 4'd5;
  localparam logic [3:0] ST_REP_VAL = 4'd6;
  localparam logic [3:0] ST_FINAL   = 4'd7;
  localparam logic [3:0] ST_FLUSH   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] di_q, di_d;
  logic       redo_q, redo_d;
  logic       final_q, final_d;
  logic       dec_end;
  logic       emit_end;

  always_comb begin
    state_d    = state_q;
    di_d       = di_q;
    redo_d     = redo_q;
    final_d    = final_q;
    dp_cmd_o   = '0;
    dp_cmd_o.di = di_q;
    pk_cmd_o   = '0;
    pk_cmd_o.done = dp_stat_i.last;
    in_ready_o = 1'b0;
    dec_end    = 1'b0;
    emit_end   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.load = 1'b1;
          if (in_last_i || dp_stat_i.fill == 2'd2) begin
            state_d = ST_DECIDE;
            di_d    = 2'd0;
          end
        end
      end
      ST_DECIDE: begin
        if (dp_stat_i.mode) begin
          if (dp_stat_i.rlen_zero) begin
            dp_cmd_o.dec_op = DEC_REP_START;
            dec_end = 1'b1;
          end else if (dp_stat_i.b_eq_rv) begin
            dp_cmd_o.dec_op = DEC_REP_INC;
            if (dp_stat_i.rep_full) begin
              state_d = ST_REP_HDR;
            end else begin
              dec_end = 1'b1;
            end
          end else begin
            state_d = ST_REP_HDR;
            redo_d  = 1'b1;
          end
        end else if (dp_stat_i.triple) begin
          dp_cmd_o.dec_op = DEC_TRIPLE;
          state_d = ST_LIT_HDR;
        end else begin
          dp_cmd_o.dec_op = DEC_LIT_STORE;
          if (dp_stat_i.lit_full) begin
            state_d = ST_LIT_HDR;
          end else begin
            dec_end = 1'b1;
          end
        end
      end
      ST_LIT_HDR: begin
        dp_cmd_o.src = SRC_LIT_HDR;
        if (dp_stat_i.llen_zero) begin
          emit_end = 1'b1;
        end else if (pk_stat_i.can_push) begin
          pk_cmd_o.push    = 1'b1;
          dp_cmd_o.ptr_clr = 1'b1;
          state_d = ST_LIT_RD;
        end
      end
      ST_LIT_RD: begin
        dp_cmd_o.ram_re = 1'b1;
        state_d = ST_LIT_WR;
      end
      ST_LIT_WR: begin
        dp_cmd_o.src = SRC_LIT_BYTE;
        if (pk_stat_i.can_push) begin
          pk_cmd_o.push    = 1'b1;
          dp_cmd_o.ptr_inc = 1'b1;
          if (dp_stat_i.lit_ptr_last) begin
            dp_cmd_o.lit_clr = 1'b1;
            emit_end = 1'b1;
          end else begin
            state_d = ST_LIT_RD;
          end
        end
      end
      ST_REP_HDR: begin
        dp_cmd_o.src = SRC_REP_HDR;
        if (dp_stat_i.rlen_zero) begin
          dp_cmd_o.rep_end = 1'b1;
          emit_end = 1'b1;
        end else if (pk_stat_i.can_push) begin
          pk_cmd_o.push    = 1'b1;
          dp_cmd_o.ptr_clr = 1'b1;
          state_d = ST_REP_VAL;
        end
      end
      ST_REP_VAL: begin
        dp_cmd_o.src = SRC_REP_VAL;
        if (pk_stat_i.can_push) begin
          pk_cmd_o.push    = 1'b1;
          dp_cmd_o.ptr_inc = 1'b1;
          if (dp_stat_i.rlen_ge3 || dp_stat_i.rep_ptr_last) begin
            dp_cmd_o.rep_end = 1'b1;
            emit_end = 1'b1;
          end
        end
      end
      ST_FINAL: begin
        final_d = 1'b1;
        state_d = dp_stat_i.mode ? ST_REP_HDR : ST_LIT_HDR;
      end
      ST_FLUSH: begin
        if (!pk_stat_i.empty) begin
          pk_cmd_o.flush = 1'b1;
        end else begin
          if (dp_stat_i.last) begin
            dp_cmd_o.clear_all = 1'b1;
          end else begin
            dp_cmd_o.shift = 1'b1;
          end
          final_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit_end && final_q) begin
      state_d = ST_FLUSH;
    end else if (emit_end && redo_q) begin
      redo_d  = 1'b0;
      state_d = ST_DECIDE;
    end else if (dec_end || emit_end) begin
      if (!dp_stat_i.last) begin
        if (dec_end && pk_stat_i.empty) begin
          dp_cmd_o.shift = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FLUSH;
        end
      end else if ((3'(di_q) + 3'd1) < 3'(dp_stat_i.fill)) begin
        di_d    = di_q + 2'd1;
        state_d = ST_DECIDE;
      end else begin
        state_d = ST_FINAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      di_q    <= '0;
      redo_q  <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      di_q    <= di_d;
      redo_q  <= redo_d;
      final_q <= final_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pk_cmd_o.push |-> pk_stat_i.can_push)
    else $error("byte pushed into a full packer");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> pk_stat_i.empty)
    else $error("new beat taken with bytes left in the packer");

  a_rd_before_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIT_WR) |-> $past(state_q == ST_LIT_RD || state_q == ST_LIT_WR))
    else $error("literal byte written without a store read");
`endif

endmodule

// ===== rtl/argb_plane_rle_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// argb_plane_rle_encoder_unit: PackBits-style run-length encoder, one plane
// A byte that closes no run is taken directly while the two-byte lookahead fills,
//   otherwise it is accepted and then passes through a decision state.
// A closed literal emits its header and then one literal store read per byte,
//   a repeat its header and its value, and a flush closes the last partial word.
// Reset clears all control and run state; the literal store is not cleared.
// ----------------------------------------------------------------------------
module argb_plane_rle_encoder_unit #(
  parameter int MAX_RUN = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  arle_in_if.sink     plane_i,
  arle_out_if.source  packed_o
);
  import arle_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_stat_t   dp_stat;
  pk_cmd_t    pk_cmd;
  pk_stat_t   pk_stat;
  logic [7:0] push_byte;
  logic       in_ready;

  assign plane_i.ready = in_ready;

  arle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (plane_i.valid),
    .in_last_i  (plane_i.plane_last),
    .in_ready_o (in_ready),
    .dp_stat_i  (dp_stat),
    .pk_stat_i  (pk_stat),
    .dp_cmd_o   (dp_cmd),
    .pk_cmd_o   (pk_cmd)
  );

  arle_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .plane_byte_i (plane_i.plane_byte),
    .plane_last_i (plane_i.plane_last),
    .stat_o       (dp_stat),
    .push_byte_o  (push_byte)
  );

  arle_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (pk_cmd),
    .byte_i (push_byte),
    .stat_o (pk_stat),
    .word_o (packed_o)
  );

endmodule
